FILE: hw/rtl/sie_pkg.sv
// shared types and constants for the small instruction execute unit
package sie_pkg;

    // default sizes
    localparam int DEF_NUM_REGS = 13;
    localparam int DEF_Y_SIZE   = 128;
    localparam int DEF_X_SIZE   = 128;

    // register index width, fixed by the instruction fields
    localparam int REG_W = 4;

    // fixed register roles
    localparam logic [REG_W-1:0] REG_X1         = 4'd0;
    localparam logic [REG_W-1:0] REG_X2         = 4'd1;
    localparam logic [REG_W-1:0] REG_CMP_A      = 4'd4;
    localparam logic [REG_W-1:0] REG_CMP_B      = 4'd5;
    localparam logic [REG_W-1:0] REG_CMP_AND    = 4'd6;
    localparam logic [REG_W-1:0] REG_STORE_DATA = 4'd5;
    localparam logic [REG_W-1:0] REG_PLANE1     = 4'd10;

    // highest defined command code
    localparam logic [4:0] CMD_LAST = 5'd18;

    // classified operation, codes follow the command encoding
    typedef enum logic [4:0] {
        OP_XOR     = 5'd0,
        OP_AND     = 5'd1,
        OP_OR      = 5'd2,
        OP_ADD     = 5'd3,
        OP_ADDI    = 5'd4,
        OP_SUBI    = 5'd5,
        OP_ANDI    = 5'd6,
        OP_EQI     = 5'd7,
        OP_INC_NEI = 5'd8,
        OP_D_EQI   = 5'd9,
        OP_MOV     = 5'd10,
        OP_MOVI    = 5'd11,
        OP_LOADF   = 5'd12,
        OP_STOREF  = 5'd13,
        OP_PIXEL   = 5'd14,
        OP_RAND    = 5'd15,
        OP_FLUSH   = 5'd16,
        OP_BRCOND  = 5'd17,
        OP_BR      = 5'd18,
        OP_NOP     = 5'd31
    } t_op;

    // event codes
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_PIXEL  = 2'd1,
        EV_FLUSH  = 2'd2,
        EV_BRANCH = 2'd3
    } t_event;

    // input instruction
    typedef struct packed {
        logic [4:0]         command;
        logic [3:0]         dest_reg;
        logic [3:0]         src_a;
        logic [3:0]         src_b;
        logic signed [63:0] immediate;
        logic signed [63:0] immediate_second;
        logic [31:0]        color;
        logic [31:0]        random_value;
    } t_in_item;

    // result record
    typedef struct packed {
        logic [1:0]         event_kind;
        logic signed [31:0] pixel_x;
        logic signed [31:0] pixel_y;
        logic [31:0]        pixel_color;
        logic               branch_taken;
        logic               address_fault;
    } t_out_item;

    // decoded instruction held in the queue
    typedef struct packed {
        t_op              op;
        logic             d_ok;
        logic             a_ok;
        logic             b_ok;
        logic [REG_W-1:0] dest;
        logic [REG_W-1:0] src_a;
        logic [REG_W-1:0] src_b;
        logic [63:0]      imm;
        logic [63:0]      imm2;
        logic [31:0]      word;
    } t_dec_item;

    // queue status towards front and back
    typedef struct packed {
        logic       full;
        logic       empty;
        logic [1:0] count;
    } t_q_status;

endpackage

FILE: hw/rtl/sie_front.sv
// front end: accepts instructions, classifies them and pushes them into the queue
module sie_front #(
    parameter int NUM_REGS = sie_pkg::DEF_NUM_REGS
) (
    input  logic                i_in_valid,
    input  sie_pkg::t_in_item   i_in_item,
    input  sie_pkg::t_q_status  i_q_status,
    output logic                o_in_stall,
    output logic                o_push,
    output sie_pkg::t_dec_item  o_dec
);
    import sie_pkg::*;

    t_op  w_op;
    logic w_writes;

    // stall only on a full queue
    assign o_in_stall = i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full;

    // map the command code, unknown codes become a no-op
    always_comb begin
        w_op = (i_in_item.command <= CMD_LAST) ? t_op'(i_in_item.command) : OP_NOP;
        unique case (w_op) inside
            OP_XOR, OP_AND, OP_OR, OP_ADD, OP_ADDI, OP_SUBI, OP_ANDI, OP_EQI,
            OP_INC_NEI, OP_MOV, OP_MOVI, OP_LOADF, OP_RAND: w_writes = 1'b1;
            default:                                       w_writes = 1'b0;
        endcase
    end

    // register index range checks and operand packing
    always_comb begin
        o_dec.op    = w_op;
        o_dec.d_ok  = w_writes &&
                      ({1'b0, i_in_item.dest_reg} < (REG_W+1)'(NUM_REGS));
        o_dec.a_ok  = {1'b0, i_in_item.src_a} < (REG_W+1)'(NUM_REGS);
        o_dec.b_ok  = {1'b0, i_in_item.src_b} < (REG_W+1)'(NUM_REGS);
        o_dec.dest  = i_in_item.dest_reg;
        o_dec.src_a = i_in_item.src_a;
        o_dec.src_b = i_in_item.src_b;
        o_dec.imm   = i_in_item.immediate;
        o_dec.imm2  = i_in_item.immediate_second;
        o_dec.word  = (w_op == OP_PIXEL) ? i_in_item.color : i_in_item.random_value;
    end

endmodule

FILE: hw/rtl/sie_queue.sv
// two-entry queue between the front end and the execute stage
module sie_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sie_pkg::t_dec_item  i_item,
    input  logic                i_pop,
    output sie_pkg::t_dec_item  o_item,
    output sie_pkg::t_q_status  o_status
);
    import sie_pkg::*;

    t_dec_item  r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_item;
    end

    assign o_item         = r_slot[r_rd_ptr];
    assign o_status.full  = r_count == 2'd2;
    assign o_status.empty = r_count == 2'd0;
    assign o_status.count = r_count;

endmodule

FILE: hw/rtl/sie_back.sv
// execute stage: register file, field memory, load writeback and result register
module sie_back #(
    parameter int NUM_REGS = sie_pkg::DEF_NUM_REGS,
    parameter int Y_SIZE   = sie_pkg::DEF_Y_SIZE,
    parameter int X_SIZE   = sie_pkg::DEF_X_SIZE
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sie_pkg::t_dec_item  i_item,
    input  sie_pkg::t_q_status  i_q_status,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sie_pkg::t_out_item  o_out_item
);
    import sie_pkg::*;

    localparam int PLANE_WORDS = X_SIZE * Y_SIZE;
    localparam int FIELD_WORDS = 2 * PLANE_WORDS;
    localparam int MEM_AW      = $clog2(FIELD_WORDS);

    logic [63:0]      r_regs [NUM_REGS];
    logic [63:0]      n_regs [NUM_REGS];
    logic [31:0]      r_field [FIELD_WORDS];
    logic [31:0]      r_mem_rdata;
    logic             r_wb_valid;
    logic [REG_W-1:0] r_wb_dest;
    t_out_item        r_out;
    logic             r_out_valid;

    logic             w_fire;
    logic [63:0]      w_a, w_b, w_x1, w_x2, w_st;
    logic [63:0]      w_addr, w_inc;
    logic             w_oor, w_eq_a, w_eq_b;
    logic             w_dest_en, w_aux_en, w_cmp_en;
    logic [63:0]      w_dest_val;
    logic             w_mem_we, w_mem_re;
    t_out_item        w_out;

    // register read with forwarding from a load still in writeback
    function automatic logic [63:0] f_read(input logic [REG_W-1:0] idx);
        logic [63:0] v;
        v = '0;
        if (r_wb_valid && r_wb_dest == idx) begin
            v = {32'b0, r_mem_rdata};
        end else if ({1'b0, idx} < (REG_W+1)'(NUM_REGS)) begin
            v = r_regs[idx];
        end
        return v;
    endfunction

    // issue when the queue holds an instruction and the result register can take a new record
    assign w_fire = !i_q_status.empty && (!r_out_valid || !i_out_stall);
    assign o_pop  = w_fire;

    // operand fetch
    always_comb begin
        w_a  = i_item.a_ok ? f_read(i_item.src_a) : 64'd0;
        w_b  = i_item.b_ok ? f_read(i_item.src_b) : 64'd0;
        w_x1 = f_read(REG_X1);
        w_x2 = f_read(REG_X2);
        w_st = f_read(REG_STORE_DATA);
    end

    // field word address and range check
    assign w_addr = w_a + w_x1 * 64'(Y_SIZE) + w_x2;
    assign w_oor  = w_addr >= 64'(FIELD_WORDS);
    assign w_inc  = w_a + 64'd1;
    assign w_eq_a = w_a == i_item.imm;
    assign w_eq_b = w_b == i_item.imm2;

    // operation select
    always_comb begin
        w_dest_en  = i_item.d_ok;
        w_dest_val = '0;
        w_aux_en   = 1'b0;
        w_cmp_en   = 1'b0;
        w_mem_we   = 1'b0;
        w_mem_re   = 1'b0;
        w_out      = '0;
        unique case (i_item.op)
            OP_XOR:     w_dest_val = w_a ^ w_b;
            OP_AND:     w_dest_val = w_a & w_b;
            OP_OR:      w_dest_val = w_a | w_b;
            OP_ADD:     w_dest_val = w_a + w_b;
            OP_ADDI:    w_dest_val = w_a + i_item.imm;
            OP_SUBI:    w_dest_val = w_a - i_item.imm;
            OP_ANDI:    w_dest_val = w_a & i_item.imm;
            OP_EQI:     w_dest_val = {63'b0, w_eq_a};
            OP_INC_NEI: begin
                w_aux_en   = i_item.a_ok;
                w_dest_val = {63'b0, w_inc != i_item.imm};
            end
            OP_D_EQI:   w_cmp_en = 1'b1;
            OP_MOV:     w_dest_val = w_a;
            OP_MOVI:    w_dest_val = i_item.imm;
            OP_LOADF: begin
                // in range: data arrives from memory in writeback, faulting: zero now
                w_dest_en           = i_item.d_ok && w_oor;
                w_mem_re            = w_fire && !w_oor;
                w_out.address_fault = w_oor;
            end
            OP_STOREF: begin
                w_mem_we            = w_fire && !w_oor;
                w_out.address_fault = w_oor;
            end
            OP_PIXEL: begin
                w_out.event_kind  = EV_PIXEL;
                w_out.pixel_x     = w_a[31:0];
                w_out.pixel_y     = w_b[31:0];
                w_out.pixel_color = i_item.word;
            end
            OP_RAND:    w_dest_val = {32'b0, i_item.word};
            OP_FLUSH:   w_out.event_kind = EV_FLUSH;
            OP_BRCOND: begin
                w_out.event_kind   = EV_BRANCH;
                w_out.branch_taken = w_a[0];
            end
            OP_BR: begin
                w_out.event_kind   = EV_BRANCH;
                w_out.branch_taken = 1'b1;
            end
            default:    w_dest_en = 1'b0;
        endcase
    end

    // register next values, later writes take priority
    always_comb begin
        for (int i = 0; i < NUM_REGS; i++) begin
            n_regs[i] = r_regs[i];
            if (r_wb_valid && r_wb_dest == REG_W'(i)) n_regs[i] = {32'b0, r_mem_rdata};
            if (w_fire) begin
                if (w_aux_en && i_item.src_a == REG_W'(i)) n_regs[i] = w_inc;
                if (w_cmp_en) begin
                    if (REG_W'(i) == REG_CMP_A)   n_regs[i] = {63'b0, w_eq_a};
                    if (REG_W'(i) == REG_CMP_B)   n_regs[i] = {63'b0, w_eq_b};
                    if (REG_W'(i) == REG_CMP_AND) n_regs[i] = {63'b0, w_eq_a && w_eq_b};
                end
                if (w_dest_en && i_item.dest == REG_W'(i)) n_regs[i] = w_dest_val;
            end
        end
    end

    // register file, plane base in its own register after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= (REG_W'(i) == REG_PLANE1) ? 64'(PLANE_WORDS) : 64'd0;
            end
        end else begin
            for (int i = 0; i < NUM_REGS; i++) r_regs[i] <= n_regs[i];
        end
    end

    // field memory, one access a cycle, registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_field[w_addr[MEM_AW-1:0]] <= w_st[31:0];
        if (w_mem_re) r_mem_rdata <= r_field[w_addr[MEM_AW-1:0]];
    end

    // load writeback tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_valid <= 1'b0;
        end else begin
            r_wb_valid <= w_mem_re && i_item.d_ok;
        end
        if (w_mem_re) r_wb_dest <= i_item.dest;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_fire) r_out <= w_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: hw/rtl/small_isa_execute_unit.sv
// execute unit top level: front end, instruction queue and execute stage
// path: an instruction is stored in the queue, then issues into the result register when that
//   register can take a new record
// throughput: one instruction per cycle unless the output stalls, set by the single execute
//   stage; loaded words are forwarded from the memory read register to the next instruction
// reset: registers cleared with the second plane base in register 10, queue and result
//   register empty; the field memory is not cleared
module small_isa_execute_unit #(
    parameter int NUM_REGS = sie_pkg::DEF_NUM_REGS,
    parameter int Y_SIZE   = sie_pkg::DEF_Y_SIZE,
    parameter int X_SIZE   = sie_pkg::DEF_X_SIZE
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sie_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sie_pkg::t_out_item  o_out_item
);
    import sie_pkg::*;

    logic      w_push;
    logic      w_pop;
    t_dec_item w_dec;
    t_dec_item w_q_item;
    t_q_status w_q_status;

    // instruction decode
    sie_front #(
        .NUM_REGS (NUM_REGS)
    ) u_front (
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_q_status (w_q_status),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_dec      (w_dec)
    );

    // decoupling queue
    sie_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_dec),
        .i_pop    (w_pop),
        .o_item   (w_q_item),
        .o_status (w_q_status)
    );

    // execute
    sie_back #(
        .NUM_REGS (NUM_REGS),
        .Y_SIZE   (Y_SIZE),
        .X_SIZE   (X_SIZE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_q_item),
        .i_q_status  (w_q_status),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // no transfer into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_status.full)
        else $error("push into full queue");

    // issue only from a filled queue and into a free result register
    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (!w_q_status.empty && !(o_out_valid && i_out_stall)))
        else $error("issue without instruction or result space");

    // fill count rises on a push without a pop
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (w_q_status.count == $past(w_q_status.count) + 2'd1))
        else $error("queue count lost a push");

    // a finished issue always shows a result
    a_issue_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> o_out_valid)
        else $error("issued instruction gave no result");

endmodule
